// ===== sv/bof_pkg.sv =====
`timescale 1ns / 1ps

package bof_pkg;

  // Fixed point format of every point: signed, FRAC_BITS fractional bits.
  localparam int FRAC_BITS = 16;
  localparam int PT_W      = 41;
  localparam int COORD_W   = 23;
  localparam int OFS_W     = 25;
  localparam int STEPS_W   = 7;

  // Curve parameter t is unsigned and may reach exactly 1.0.
  localparam int T_W       = FRAC_BITS + 1;
  localparam int MAG_W     = PT_W + 1;
  localparam int HI_W      = MAG_W - FRAC_BITS;
  localparam int PROD_W    = HI_W + T_W;
  localparam int LO_PROD_W = FRAC_BITS + T_W;

  localparam int MAX_STEPS_DEF = 64;
  localparam int STEPS_RESET   = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 2'd2;

  typedef enum logic [1:0] {
    FUNC_MOVE,
    FUNC_LINE,
    FUNC_QUAD,
    FUNC_CUBIC
  } func_t;

  // Working slots of the point store, one set per axis.
  localparam int SLOT_W    = 4;
  localparam int NUM_SLOTS = 10;
  localparam int MEM_DEPTH = 2 * NUM_SLOTS;
  localparam int ADDR_W    = SLOT_W + 1;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_P,
    SLOT_A,
    SLOT_B,
    SLOT_E,
    SLOT_F,
    SLOT_G,
    SLOT_H,
    SLOT_D,
    SLOT_K,
    SLOT_X
  } slot_t;

  typedef struct packed {
    slot_t src_a;
    slot_t src_b;
    slot_t dst;
  } lerp_op_t;

  typedef logic [2:0] op_idx_t;

  typedef struct packed {
    logic [PT_W-1:0] a;
    logic [PT_W-1:0] b;
    logic [T_W-1:0]  t;
  } lerp_req_t;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_MHI,
    LP_MLO,
    LP_SUM,
    LP_FIN
  } lerp_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIRECT,
    ST_LOAD,
    ST_DIV,
    ST_TSTEP,
    ST_RD,
    ST_LSTART,
    ST_LWAIT,
    ST_EMIT
  } state_t;

  // de Casteljau order of interpolations for one axis of one point.
  function automatic lerp_op_t lerp_schedule(func_t f, op_idx_t op);
    lerp_op_t s;
    s = '{src_a: SLOT_P, src_b: SLOT_A, dst: SLOT_F};
    if (f == FUNC_CUBIC) begin
      case (op)
        3'd0: s = '{src_a: SLOT_P, src_b: SLOT_A, dst: SLOT_F};
        3'd1: s = '{src_a: SLOT_A, src_b: SLOT_B, dst: SLOT_G};
        3'd2: s = '{src_a: SLOT_B, src_b: SLOT_E, dst: SLOT_H};
        3'd3: s = '{src_a: SLOT_F, src_b: SLOT_G, dst: SLOT_D};
        3'd4: s = '{src_a: SLOT_G, src_b: SLOT_H, dst: SLOT_K};
        default: s = '{src_a: SLOT_D, src_b: SLOT_K, dst: SLOT_X};
      endcase
    end else begin
      case (op)
        3'd0: s = '{src_a: SLOT_P, src_b: SLOT_A, dst: SLOT_F};
        3'd1: s = '{src_a: SLOT_A, src_b: SLOT_E, dst: SLOT_G};
        default: s = '{src_a: SLOT_F, src_b: SLOT_G, dst: SLOT_X};
      endcase
    end
    return s;
  endfunction

  function automatic op_idx_t last_op(func_t f);
    return (f == FUNC_CUBIC) ? op_idx_t'(5) : op_idx_t'(2);
  endfunction

  // Input coordinate plus half-unit offset, both scaled to the point format.
  function automatic logic signed [PT_W-1:0] to_fixed(logic signed [COORD_W-1:0] c,
                                                      logic signed [OFS_W-1:0] off);
    logic signed [PT_W-1:0] cs;
    logic signed [PT_W-1:0] os;
    cs = PT_W'(c);
    os = PT_W'(off);
    return (cs <<< FRAC_BITS) + (os <<< (FRAC_BITS - 1));
  endfunction

endpackage

// ===== sv/bof_seg_if.sv =====
`timescale 1ns / 1ps

interface bof_seg_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic signed [bof_pkg::COORD_W-1:0]   ctrl_a_x;
  logic signed [bof_pkg::COORD_W-1:0]   ctrl_a_y;
  logic signed [bof_pkg::COORD_W-1:0]   ctrl_b_x;
  logic signed [bof_pkg::COORD_W-1:0]   ctrl_b_y;
  logic signed [bof_pkg::COORD_W-1:0]   end_x;
  logic signed [bof_pkg::COORD_W-1:0]   end_y;

  modport source (
    output valid, func, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, func, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
    output ready
  );
endinterface

// ===== sv/bof_pt_if.sv =====
`timescale 1ns / 1ps

interface bof_pt_if;
  logic                              valid;
  logic                              ready;
  logic signed [bof_pkg::PT_W-1:0]   point_x;
  logic signed [bof_pkg::PT_W-1:0]   point_y;
  logic                              starts_contour;
  logic                              last_of_run;

  modport source (
    output valid, point_x, point_y, starts_contour, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, starts_contour, last_of_run,
    output ready
  );
endinterface

// ===== sv/bof_lerp_unit.sv =====
`timescale 1ns / 1ps

// Rounded interpolation a + sign(b-a) * round(|b-a| * t), half away from zero.
// The magnitude is split at the binary point and both halves go through one
// multiplier in consecutive cycles. Result is valid while done is high.
module bof_lerp_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  bof_pkg::lerp_req_t             req,
  output logic                           done,
  output logic signed [bof_pkg::PT_W-1:0] result
);

  localparam logic [bof_pkg::LO_PROD_W:0] HALF =
    (bof_pkg::LO_PROD_W + 1)'(1) << (bof_pkg::FRAC_BITS - 1);

  bof_pkg::lerp_phase_t phase, phase_next;

  logic signed [bof_pkg::MAG_W-1:0]     diff;
  logic [bof_pkg::MAG_W-1:0]            mag;
  logic                                 neg;
  logic signed [bof_pkg::PT_W-1:0]      a_r;
  logic [bof_pkg::MAG_W-1:0]            mag_r;
  logic                                 neg_r;
  logic [bof_pkg::T_W-1:0]              t_r;
  logic [bof_pkg::HI_W-1:0]             mul_a;
  logic [bof_pkg::PROD_W-1:0]           prod;
  logic [bof_pkg::PROD_W-1:0]           p_hi;
  logic [bof_pkg::LO_PROD_W-1:0]        p_lo;
  logic [bof_pkg::LO_PROD_W:0]          lo_round;
  logic [bof_pkg::PROD_W-1:0]           sum;
  logic [bof_pkg::PROD_W-1:0]           r_sum;

  always_comb begin
    diff = bof_pkg::MAG_W'($signed(req.b)) - bof_pkg::MAG_W'($signed(req.a));
    neg  = diff[bof_pkg::MAG_W-1];
    mag  = neg ? bof_pkg::MAG_W'(-diff) : bof_pkg::MAG_W'(diff);
  end

  always_comb begin
    if (phase == bof_pkg::LP_MLO) begin
      mul_a = bof_pkg::HI_W'(mag_r[bof_pkg::FRAC_BITS-1:0]);
    end else begin
      mul_a = mag_r[bof_pkg::MAG_W-1:bof_pkg::FRAC_BITS];
    end
    prod     = bof_pkg::PROD_W'(mul_a) * bof_pkg::PROD_W'(t_r);
    lo_round = (bof_pkg::LO_PROD_W + 1)'(p_lo) + HALF;
    sum      = p_hi + bof_pkg::PROD_W'(lo_round[bof_pkg::LO_PROD_W:bof_pkg::FRAC_BITS]);
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      bof_pkg::LP_IDLE: begin
        if (start) begin
          phase_next = bof_pkg::LP_MHI;
        end
      end
      bof_pkg::LP_MHI: phase_next = bof_pkg::LP_MLO;
      bof_pkg::LP_MLO: phase_next = bof_pkg::LP_SUM;
      bof_pkg::LP_SUM: phase_next = bof_pkg::LP_FIN;
      bof_pkg::LP_FIN: phase_next = bof_pkg::LP_IDLE;
      default:         phase_next = bof_pkg::LP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bof_pkg::LP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == bof_pkg::LP_IDLE && start) begin
      a_r   <= $signed(req.a);
      mag_r <= mag;
      neg_r <= neg;
      t_r   <= req.t;
    end
    if (phase == bof_pkg::LP_MHI) begin
      p_hi <= prod;
    end
    if (phase == bof_pkg::LP_MLO) begin
      p_lo <= prod[bof_pkg::LO_PROD_W-1:0];
    end
    if (phase == bof_pkg::LP_SUM) begin
      r_sum <= sum;
    end
  end

  assign done   = (phase == bof_pkg::LP_FIN);
  assign result = neg_r ? a_r - $signed(r_sum[bof_pkg::PT_W-1:0])
                        : a_r + $signed(r_sum[bof_pkg::PT_W-1:0]);

endmodule

// ===== sv/bezier_outline_flattener_unit.sv =====
`timescale 1ns / 1ps

// Outline flattener: takes one outline segment per transfer on seg (move, line,
// quadratic or cubic curve), shifts every point by the configured half-unit
// offsets, and produces points on pt in signed fixed point with 16 fractional
// bits. A move or a line gives one point. A curve gives n points (n is
// curve_steps, with 0 read as 1 and values above MAX_STEPS read as
// MAX_STEPS) at t = (i+1)/n rounded to 16 fractional bits, evaluated by de
// Casteljau from the current point. All interpolations run one after another
// through a single rounding interpolator built around one 26x17 multiplier,
// and each interpolation consists of a store read, a start, two multiplies,
// a sum and the final add. A curve segment first loads the working store,
// then runs the bit-serial divider that yields the step of t, and each point
// then advances t, runs its interpolations and hands over its point.
// seg.ready is high only while the block is idle; a point waiting in the
// output register does not hold off the next segment, but a new point waits
// until the previous one has been taken. The last point of a segment becomes
// the current point. Configuration writes are meant for times when no
// segment is in flight.
module bezier_outline_flattener_unit #(
  parameter int MAX_STEPS = bof_pkg::MAX_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bof_pkg::CFG_DATA_W-1:0]    cfg_data,
  bof_seg_if.sink                           seg,
  bof_pt_if.source                          pt
);

  // Width of a step count and of the point index within a curve.
  localparam int N_W       = $clog2(MAX_STEPS + 1);
  localparam int CW        = (N_W > bof_pkg::STEPS_W) ? N_W : bof_pkg::STEPS_W;
  localparam int DIV_CNT_W = $clog2(bof_pkg::T_W);
  localparam logic [bof_pkg::T_W-1:0] T_ONE = bof_pkg::T_W'(1) << bof_pkg::FRAC_BITS;

  // Configuration registers.
  logic [bof_pkg::STEPS_W-1:0]       steps;
  logic signed [bof_pkg::OFS_W-1:0]  off_x;
  logic signed [bof_pkg::OFS_W-1:0]  off_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= bof_pkg::STEPS_W'(bof_pkg::STEPS_RESET);
      off_x <= '0;
      off_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bof_pkg::REG_CURVE_STEPS: steps <= cfg_data[bof_pkg::STEPS_W-1:0];
        bof_pkg::REG_OFFSET_X:    off_x <= $signed(cfg_data[bof_pkg::OFS_W-1:0]);
        bof_pkg::REG_OFFSET_Y:    off_y <= $signed(cfg_data[bof_pkg::OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Effective step count: zero acts as one, the count is capped at MAX_STEPS.
  logic [CW-1:0]  steps_c;
  logic [CW-1:0]  n_c;
  logic [N_W-1:0] n;

  always_comb begin
    steps_c = CW'(steps);
    if (steps_c == '0) begin
      n_c = CW'(1);
    end else if (steps_c > CW'(MAX_STEPS)) begin
      n_c = CW'(MAX_STEPS);
    end else begin
      n_c = steps_c;
    end
    n = N_W'(n_c);
  end

  // Sequencer state and the captured segment.
  bof_pkg::state_t state, state_next;

  bof_pkg::func_t                     func_r;
  logic signed [bof_pkg::COORD_W-1:0] ax, ay, bx, by, ex, ey;
  logic signed [bof_pkg::PT_W-1:0]    cur_x, cur_y;
  logic signed [bof_pkg::PT_W-1:0]    ox, oy;

  logic [2:0]                 ld_cnt;
  logic                       ld_axis;
  bof_pkg::slot_t             ld_slot;
  logic signed [bof_pkg::COORD_W-1:0] ld_fld;
  logic signed [bof_pkg::OFS_W-1:0]   ld_off;
  logic signed [bof_pkg::PT_W-1:0]    ld_val;

  // Divider for 2^FRAC_BITS / n, then the running t = round((i+1)/n).
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [N_W-1:0]           rem;
  logic [N_W:0]             rem_sh;
  logic                     rem_ge;
  logic [bof_pkg::T_W-1:0]  q0;
  logic [bof_pkg::T_W-1:0]  tq;
  logic [N_W-1:0]           tr;
  logic [N_W:0]             tr_sum;
  logic                     tr_carry;
  logic [N_W-1:0]           pt_cnt;
  logic                     pt_last;

  bof_pkg::op_idx_t         op;
  logic                     axis;
  bof_pkg::lerp_op_t        sched;

  // Point store: one slot set per axis, addressed {slot, axis}.
  logic signed [bof_pkg::PT_W-1:0] mem [bof_pkg::MEM_DEPTH];
  logic                            mem_we;
  logic [bof_pkg::ADDR_W-1:0]      mem_waddr;
  logic signed [bof_pkg::PT_W-1:0] mem_wdata;
  logic [bof_pkg::ADDR_W-1:0]      raddr_a, raddr_b;
  logic signed [bof_pkg::PT_W-1:0] rd_a, rd_b;

  bof_pkg::lerp_req_t              lerp_req;
  logic                            lerp_start;
  logic                            lerp_done;
  logic signed [bof_pkg::PT_W-1:0] lerp_res;

  // Output register.
  logic                            out_valid;
  logic signed [bof_pkg::PT_W-1:0] out_x, out_y;
  logic                            out_start, out_last;
  logic                            out_free;
  logic                            out_load;
  logic signed [bof_pkg::PT_W-1:0] end_fx, end_fy;

  assign out_free = !out_valid || pt.ready;
  assign end_fx   = bof_pkg::to_fixed(ex, off_x);
  assign end_fy   = bof_pkg::to_fixed(ey, off_y);
  assign pt_last  = (pt_cnt == n - N_W'(1));

  // Loading the store: for each axis the current point, then A, B and E.
  always_comb begin
    ld_axis = ld_cnt[2];
    ld_slot = bof_pkg::slot_t'(bof_pkg::SLOT_W'(ld_cnt[1:0]));
    ld_off  = ld_axis ? off_y : off_x;
    case (ld_slot)
      bof_pkg::SLOT_A: ld_fld = ld_axis ? ay : ax;
      bof_pkg::SLOT_B: ld_fld = ld_axis ? by : bx;
      default:         ld_fld = ld_axis ? ey : ex;
    endcase
    if (ld_slot == bof_pkg::SLOT_P) begin
      ld_val = ld_axis ? cur_y : cur_x;
    end else begin
      ld_val = bof_pkg::to_fixed(ld_fld, ld_off);
    end
  end

  always_comb begin
    rem_sh   = {rem, (div_cnt == '0)};
    rem_ge   = (rem_sh >= (N_W + 1)'(n));
    tr_sum   = (N_W + 1)'(tr) + (N_W + 1)'(rem);
    tr_carry = (tr_sum >= (N_W + 1)'(n));
  end

  always_comb begin
    sched   = bof_pkg::lerp_schedule(func_r, op);
    raddr_a = {sched.src_a, axis};
    raddr_b = {sched.src_b, axis};
    if (state == bof_pkg::ST_LOAD) begin
      mem_waddr = {ld_slot, ld_axis};
      mem_wdata = ld_val;
    end else begin
      mem_waddr = {sched.dst, axis};
      mem_wdata = lerp_res;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    seg.ready  = 1'b0;
    mem_we     = 1'b0;
    lerp_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      bof_pkg::ST_IDLE: begin
        seg.ready = 1'b1;
        if (seg.valid) begin
          if (bof_pkg::func_t'(seg.func) inside {bof_pkg::FUNC_MOVE, bof_pkg::FUNC_LINE}) begin
            state_next = bof_pkg::ST_DIRECT;
          end else begin
            state_next = bof_pkg::ST_LOAD;
          end
        end
      end
      bof_pkg::ST_DIRECT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = bof_pkg::ST_IDLE;
        end
      end
      bof_pkg::ST_LOAD: begin
        mem_we = 1'b1;
        if (ld_cnt == 3'd7) begin
          state_next = bof_pkg::ST_DIV;
        end
      end
      bof_pkg::ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(bof_pkg::T_W - 1)) begin
          state_next = bof_pkg::ST_TSTEP;
        end
      end
      bof_pkg::ST_TSTEP:  state_next = bof_pkg::ST_RD;
      bof_pkg::ST_RD:     state_next = bof_pkg::ST_LSTART;
      bof_pkg::ST_LSTART: begin
        lerp_start = 1'b1;
        state_next = bof_pkg::ST_LWAIT;
      end
      bof_pkg::ST_LWAIT: begin
        if (lerp_done) begin
          mem_we = 1'b1;
          if (op == bof_pkg::last_op(func_r) && axis) begin
            state_next = bof_pkg::ST_EMIT;
          end else begin
            state_next = bof_pkg::ST_RD;
          end
        end
      end
      bof_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pt_last) begin
            state_next = bof_pkg::ST_IDLE;
          end else begin
            state_next = bof_pkg::ST_TSTEP;
          end
        end
      end
      default: state_next = bof_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bof_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Segment capture and sequencing counters.
  always_ff @(posedge clk) begin
    if (state == bof_pkg::ST_IDLE && seg.valid) begin
      func_r  <= bof_pkg::func_t'(seg.func);
      ax      <= seg.ctrl_a_x;
      ay      <= seg.ctrl_a_y;
      bx      <= seg.ctrl_b_x;
      by      <= seg.ctrl_b_y;
      ex      <= seg.end_x;
      ey      <= seg.end_y;
      ld_cnt  <= '0;
      div_cnt <= '0;
      rem     <= '0;
      q0      <= '0;
    end
    if (state == bof_pkg::ST_LOAD) begin
      ld_cnt <= ld_cnt + 3'd1;
    end
    if (state == bof_pkg::ST_DIV) begin
      // One quotient bit per cycle; the dividend is a single one bit.
      rem     <= rem_ge ? N_W'(rem_sh - (N_W + 1)'(n)) : N_W'(rem_sh);
      q0      <= {q0[bof_pkg::T_W-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      tq      <= '0;
      tr      <= n >> 1;
      pt_cnt  <= '0;
    end
    if (state == bof_pkg::ST_TSTEP) begin
      // Add 2^FRAC_BITS / n as quotient and remainder; one carry at most.
      tq   <= tq + q0 + bof_pkg::T_W'(tr_carry);
      tr   <= tr_carry ? N_W'(tr_sum - (N_W + 1)'(n)) : N_W'(tr_sum);
      op   <= '0;
      axis <= 1'b0;
    end
    if (state == bof_pkg::ST_LWAIT && lerp_done) begin
      if (sched.dst == bof_pkg::SLOT_X) begin
        if (axis) begin
          oy <= lerp_res;
        end else begin
          ox <= lerp_res;
        end
      end
      if (op == bof_pkg::last_op(func_r)) begin
        op   <= '0;
        axis <= 1'b1;
      end else begin
        op <= op + bof_pkg::op_idx_t'(1);
      end
    end
    if (state == bof_pkg::ST_EMIT && out_free) begin
      pt_cnt <= pt_cnt + N_W'(1);
    end
  end

  // Current point.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
    end else if (state == bof_pkg::ST_DIRECT && out_free) begin
      cur_x <= end_fx;
      cur_y <= end_fy;
    end else if (state == bof_pkg::ST_EMIT && out_free && pt_last) begin
      cur_x <= ox;
      cur_y <= oy;
    end
  end

  // Point store with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  assign lerp_req = '{a: rd_a, b: rd_b, t: tq};

  bof_lerp_unit u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .req    (lerp_req),
    .done   (lerp_done),
    .result (lerp_res)
  );

  // Output register: a held point is dropped once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == bof_pkg::ST_DIRECT) begin
        out_x     <= end_fx;
        out_y     <= end_fy;
        out_start <= (func_r == bof_pkg::FUNC_MOVE);
        out_last  <= 1'b1;
      end else begin
        out_x     <= ox;
        out_y     <= oy;
        out_start <= 1'b0;
        out_last  <= pt_last;
      end
    end
  end

  assign pt.valid          = out_valid;
  assign pt.point_x        = out_x;
  assign pt.point_y        = out_y;
  assign pt.starts_contour = out_start;
  assign pt.last_of_run    = out_last;

  // The interpolator only finishes while the sequencer waits for it.
  a_lerp_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    lerp_done |-> state == bof_pkg::ST_LWAIT)
    else $error("interpolator finished outside its wait state");

  // The running remainder of t stays below the step count.
  a_t_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == bof_pkg::ST_TSTEP |-> tr < n)
    else $error("t remainder out of range");

  // The final point of a curve is evaluated at exactly t = 1.
  a_last_t_one: assert property (@(posedge clk) disable iff (rst)
    (state == bof_pkg::ST_EMIT && pt_last) |-> tq == T_ONE)
    else $error("last curve point not at t = 1");

endmodule
